// ===== src/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope package
// Amplitude format, envelope phase and sequencer state types, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

    localparam int FRAC_BITS = 24;
    localparam int AMP_W     = 25;
    localparam int CFG_IDX_W = 3;

    localparam int ONE_INT = 1 << FRAC_BITS;
    localparam int EPS_INT = (ONE_INT + 50000) / 100000;

    localparam logic [AMP_W-1:0] AMP_ONE      = AMP_W'(ONE_INT);
    localparam logic [AMP_W:0]   AMP_EPS      = (AMP_W + 1)'(EPS_INT);
    localparam logic [AMP_W:0]   ATTACK_LIMIT = (AMP_W + 1)'(ONE_INT - EPS_INT);

    localparam logic [AMP_W-1:0] RST_ATTACK_STEP    = AMP_W'(16777216);
    localparam logic [AMP_W-1:0] RST_DECAY_FACTOR   = AMP_W'(16776000);
    localparam logic [AMP_W-1:0] RST_SUSTAIN_LEVEL  = AMP_W'(16777216);
    localparam logic [AMP_W-1:0] RST_RELEASE_FACTOR = AMP_W'(16776000);

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_FACTOR = 3'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ATTACK,
        ST_DMUL,
        ST_DCHK,
        ST_SUS,
        ST_RMUL,
        ST_RCHK,
        ST_SMUL,
        ST_SCALE,
        ST_FINISH
    } seq_state_t;

endpackage : adsr_pkg

`default_nettype wire

// ===== src/adsr_if.sv =====
// ----------------------------------------------------------------------------
// ADSR channel interfaces
// Valid/ready channels for samples in, shaped samples out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           gate;

    modport source (output valid, output sample_in, output gate, input ready);
    modport sink   (input valid, input sample_in, input gate, output ready);
endinterface : adsr_in_if

interface adsr_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    import adsr_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic        [AMP_W-1:0]        amplitude;
    logic        [2:0]              phase;

    modport source (output valid, output sample_out, output amplitude, output phase,
                    input ready);
    modport sink   (input valid, input sample_out, input amplitude, input phase,
                    output ready);
endinterface : adsr_out_if

interface adsr_cfg_if;
    import adsr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [AMP_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : adsr_cfg_if

`default_nettype wire

// ===== src/adsr_mul.sv =====
// ----------------------------------------------------------------------------
// ADSR shared multiplier
// Signed multiplier with registered product, shared by the decay and release steps and the sample scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_mul #(
    parameter int A_W = 26,
    parameter int B_W = 26
) (
    input  wire logic                     clk,
    input  wire logic                     load,
    input  wire logic signed [A_W-1:0]    op_a,
    input  wire logic signed [B_W-1:0]    op_b,
    output logic signed [A_W+B_W-1:0]     prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule : adsr_mul

`default_nettype wire

// ===== src/adsr_envelope_generator.sv =====
// Sequence: an input transfer starts the attack step; decay multiply and check, the
//   sustain step, release multiply and check, and output scaling follow when needed;
//   finish waits for a free output slot.
// Flow: one sample at a time; the input is ready only in idle, and the single shared
//   multiplier is stepped through by the sequencer.
// Reset: asynchronous; registers return to their defaults, envelope idle, zero.
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Per-sample attack/decay/sustain/release envelope applied to an audio sample.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    adsr_in_if.sink    req,
    adsr_out_if.source rsp,
    adsr_cfg_if.sink   cfg
);

    localparam int MA_W = ((SAMPLE_WIDTH > AMP_W) ? SAMPLE_WIDTH : AMP_W) + 1;
    localparam int MB_W = AMP_W + 1;
    localparam int PW   = MA_W + MB_W;

    localparam logic signed [PW-1:0] S_MAX =
        {{(PW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] S_MIN = ~S_MAX;

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic [AMP_W-1:0] attack_reg, decay_reg, sustain_reg, release_reg;
    logic [AMP_W-1:0] amp_reg, amp_next;
    logic signed [SAMPLE_WIDTH-1:0] held_reg, held_next;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg, smp_next;
    logic gate_reg, gate_next;
    logic formed_reg, formed_next;

    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_smp_reg, out_smp_next;
    logic [AMP_W-1:0]               out_amp_reg, out_amp_next;
    phase_t                         out_phase_reg, out_phase_next;

    logic                   mul_load;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_sh;
    logic [AMP_W:0]         prod_q;
    logic [AMP_W-1:0]       prod_amp;
    logic signed [SAMPLE_WIDTH-1:0] prod_smp;
    logic [AMP_W-1:0]       sus_lvl;
    logic                   in_xfer;
    logic                   slot_free;

    assign in_xfer   = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign sus_lvl   = (sustain_reg > AMP_ONE) ? AMP_ONE : sustain_reg;

    adsr_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk  (clk),
        .load (mul_load),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // floor(product / ONE) for both the Q-multiply and the sample scaling
    assign prod_sh  = prod >>> FRAC_BITS;
    assign prod_q   = prod_sh[AMP_W:0];
    assign prod_amp = (prod_q > {1'b0, AMP_ONE}) ? AMP_ONE : prod_q[AMP_W-1:0];
    assign prod_smp = (prod_sh > S_MAX) ? S_MAX[SAMPLE_WIDTH-1:0] :
                      (prod_sh < S_MIN) ? S_MIN[SAMPLE_WIDTH-1:0] :
                      prod_sh[SAMPLE_WIDTH-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_ATTACK;
                end
            end
            ST_ATTACK:
            begin
                state_next = (phase_next == PH_DECAY) ? ST_DMUL : ST_SUS;
            end
            ST_DMUL:  state_next = ST_DCHK;
            ST_DCHK:  state_next = ST_SUS;
            ST_SUS:
            begin
                if (phase_next == PH_RELEASE && amp_reg != '0)
                begin
                    state_next = ST_RMUL;
                end
                else if (formed_next)
                begin
                    state_next = ST_SMUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RMUL:  state_next = ST_RCHK;
            ST_RCHK:  state_next = ST_SMUL;
            ST_SMUL:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        logic [AMP_W:0] sum;
        phase_t         ph;

        phase_next     = phase_reg;
        amp_next       = amp_reg;
        held_next      = held_reg;
        smp_next       = smp_reg;
        gate_next      = gate_reg;
        formed_next    = formed_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_smp_next   = out_smp_reg;
        out_amp_next   = out_amp_reg;
        out_phase_next = out_phase_reg;
        mul_load       = 1'b0;
        mul_a          = $signed({{(MA_W - AMP_W){1'b0}}, decay_reg});
        mul_b          = $signed({1'b0, amp_reg});
        sum            = {1'b0, amp_reg} + {1'b0, attack_reg};
        ph             = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    smp_next    = req.sample_in;
                    gate_next   = req.gate;
                    formed_next = 1'b0;
                end
            end
            ST_ATTACK:
            begin
                if (gate_reg && (ph == PH_IDLE || ph == PH_RELEASE))
                begin
                    ph = PH_ATTACK;
                end
                if (ph == PH_ATTACK)
                begin
                    formed_next = 1'b1;
                    if (sum >= ATTACK_LIMIT)
                    begin
                        amp_next = AMP_ONE;
                        ph       = PH_DECAY;
                    end
                    else
                    begin
                        amp_next = sum[AMP_W-1:0];
                    end
                end
                phase_next = ph;
            end
            ST_DMUL:
            begin
                mul_load = 1'b1;
            end
            ST_DCHK:
            begin
                formed_next = 1'b1;
                if ({1'b0, prod_amp} <= {1'b0, sus_lvl} + AMP_EPS)
                begin
                    amp_next   = sus_lvl;
                    phase_next = PH_SUSTAIN;
                end
                else
                begin
                    amp_next = prod_amp;
                end
            end
            ST_SUS:
            begin
                if (phase_reg == PH_SUSTAIN)
                begin
                    formed_next = 1'b1;
                    if (!gate_reg)
                    begin
                        phase_next = PH_RELEASE;
                    end
                end
            end
            ST_RMUL:
            begin
                mul_load = 1'b1;
                mul_a    = $signed({{(MA_W - AMP_W){1'b0}}, release_reg});
            end
            ST_RCHK:
            begin
                formed_next = 1'b1;
                amp_next    = prod_amp;
            end
            ST_SMUL:
            begin
                mul_load = 1'b1;
                mul_a    = $signed({{(MA_W - SAMPLE_WIDTH){smp_reg[SAMPLE_WIDTH-1]}}, smp_reg});
            end
            ST_SCALE:
            begin
                held_next = prod_smp;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_smp_next   = held_reg;
                    out_amp_next   = amp_reg;
                    out_phase_next = phase_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            amp_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            attack_reg    <= RST_ATTACK_STEP;
            decay_reg     <= RST_DECAY_FACTOR;
            sustain_reg   <= RST_SUSTAIN_LEVEL;
            release_reg   <= RST_RELEASE_FACTOR;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            amp_reg       <= amp_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_ATTACK_STEP:    attack_reg  <= cfg.data;
                    CFG_DECAY_FACTOR:   decay_reg   <= cfg.data;
                    CFG_SUSTAIN_LEVEL:  sustain_reg <= cfg.data;
                    CFG_RELEASE_FACTOR: release_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg       <= smp_next;
        gate_reg      <= gate_next;
        formed_reg    <= formed_next;
        out_smp_reg   <= out_smp_next;
        out_amp_reg   <= out_amp_next;
        out_phase_reg <= out_phase_next;
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.sample_out = out_smp_reg;
    assign rsp.amplitude  = out_amp_reg;
    assign rsp.phase      = out_phase_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_ATTACK)
        else $error("input transfer did not start the sequencer");

    a_amp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        amp_reg <= AMP_ONE)
        else $error("envelope amplitude above one");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !rsp.ready) |=>
            (state_reg == ST_FINISH && out_valid_reg))
        else $error("result overwritten before transfer");

    a_no_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |=> phase_reg != PH_IDLE)
        else $error("envelope returned to idle phase");
`endif

endmodule : adsr_envelope_generator

`default_nettype wire
